// ===== sv/fhp_pkg.sv =====
package fhp_pkg;

  localparam int unsigned HDR_LEN     = 8;
  localparam int unsigned COUNT_W     = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

  typedef enum logic [1:0] {
    REG_LOCAL_VERSION = 2'd0,
    REG_TYPE_LOW      = 2'd1,
    REG_TYPE_HIGH     = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_BAD_VER    = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_BAD_LENGTH = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] local_version;
    logic [7:0] type_low;
    logic [7:0] type_high;
  } cfg_t;

  // one closed buffer waiting for its verdict
  typedef struct packed {
    logic [HDR_LEN*8-1:0] hdr;
    logic [COUNT_W-1:0]   total;
  } job_t;

endpackage

// ===== sv/frame_header_parser_core.sv =====
// Frame header parser.
// Input channel: data_valid / data_stall with data_byte and buffer_end, one
// byte of a received buffer per word; buffer_end marks its last byte.
// The first eight bytes are taken as the header; later bytes are counted.
// Output channel: result_valid / result_stall, one verdict word per buffer,
// carrying status and the header fields (zero unless status is ok).
// Throughput: one byte per cycle while data_stall is low. The edge that
// takes the last byte loads the job register; the verdict word is then
// registered in the output register (one job register, one output register).
// A stalled verdict holds; bytes keep flowing until a second buffer closes
// behind it, then data_stall rises until the output register frees.
// Reset (rst, synchronous) clears the byte count and both valid flags and
// loads local_version=1, type_low=1, type_high=7.
// Config: cfg_write with cfg_index/cfg_data, only while idle; index 3 is
// ignored.
module frame_header_parser_core
  import fhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [7:0]  version,
  output logic [7:0]  frame_type,
  output logic [15:0] sequence_res,
  output logic [7:0]  flag_bits,
  output logic [7:0]  epoch,
  output logic [15:0] payload_length
);

  cfg_t cfg;
  logic job_valid;
  logic job_take;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_version <= 8'd1;
      cfg.type_low      <= 8'd1;
      cfg.type_high     <= 8'd7;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOCAL_VERSION: cfg.local_version <= cfg_data;
        REG_TYPE_LOW:      cfg.type_low      <= cfg_data;
        REG_TYPE_HIGH:     cfg.type_high     <= cfg_data;
        default: ;
      endcase
    end
  end

  fhp_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .job_take   (job_take),
    .job_valid  (job_valid),
    .job        (job)
  );

  fhp_verdict u_verdict (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .job_valid      (job_valid),
    .job            (job),
    .job_take       (job_take),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .version        (version),
    .frame_type     (frame_type),
    .sequence_res   (sequence_res),
    .flag_bits      (flag_bits),
    .epoch          (epoch),
    .payload_length (payload_length)
  );

endmodule

// ===== sv/fhp_capture.sv =====
module fhp_capture
  import fhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  input  logic       job_take,
  output logic       job_valid,
  output job_t       job
);

  logic [COUNT_W-1:0]   byte_count;
  logic [COUNT_W-1:0]   count_next;
  logic [HDR_LEN*8-1:0] hdr;
  logic [HDR_LEN*8-1:0] hdr_next;
  logic                 in_header;
  logic                 accept;

  assign data_stall = job_valid && !job_take;
  assign accept     = data_valid && !data_stall;
  assign in_header  = (byte_count[COUNT_W-1:3] == '0);
  assign count_next = (byte_count == COUNT_MAX) ? COUNT_MAX : byte_count + 1'b1;

  always_comb begin
    hdr_next = hdr;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (in_header && (byte_count[2:0] == 3'(i))) begin
        hdr_next[i*8 +: 8] = data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      job_valid  <= 1'b0;
    end else begin
      if (accept) begin
        byte_count <= buffer_end ? '0 : count_next;
      end
      if (accept && buffer_end) begin
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= hdr_next;
    end
    if (accept && buffer_end) begin
      job.hdr   <= hdr_next;
      job.total <= count_next;
    end
  end

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    accept && buffer_end |=> byte_count == '0)
    else $error("byte count not cleared after buffer end");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    accept && !buffer_end && byte_count != COUNT_MAX
      |=> byte_count == $past(byte_count) + 1'b1)
    else $error("byte count did not advance");

  a_job_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && buffer_end |=> job_valid)
    else $error("closed buffer produced no job");

  a_job_holds: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_take |=> job_valid && $stable(job))
    else $error("pending job lost or changed");

endmodule

// ===== sv/fhp_verdict.sv =====
module fhp_verdict
  import fhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [7:0]  version,
  output logic [7:0]  frame_type,
  output logic [15:0] sequence_res,
  output logic [7:0]  flag_bits,
  output logic [7:0]  epoch,
  output logic [15:0] payload_length
);

  logic [7:0]         ver;
  logic [7:0]         typ;
  logic [15:0]        len;
  logic [COUNT_W-1:0] need;
  status_t            st_next;
  logic               ok;

  assign ver  = job.hdr[7:0];
  assign typ  = job.hdr[15:8];
  assign len  = job.hdr[63:48];
  assign need = COUNT_W'(HDR_LEN) + COUNT_W'(len);

  always_comb begin
    if (job.total < COUNT_W'(HDR_LEN)) begin
      st_next = ST_TRUNCATED;
    end else if (ver == 8'd0 || ver != cfg.local_version) begin
      st_next = ST_BAD_VER;
    end else if (typ < cfg.type_low || typ > cfg.type_high) begin
      st_next = ST_BAD_TYPE;
    end else if (len > MAX_PAYLOAD) begin
      st_next = ST_BAD_LENGTH;
    end else if (job.total < need) begin
      st_next = ST_TRUNCATED;
    end else begin
      st_next = ST_OK;
    end
  end

  assign ok       = (st_next == ST_OK);
  assign job_take = job_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (job_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      status         <= st_next;
      version        <= ok ? ver : 8'd0;
      frame_type     <= ok ? typ : 8'd0;
      sequence_res   <= ok ? job.hdr[31:16] : 16'd0;
      flag_bits      <= ok ? job.hdr[39:32] : 8'd0;
      epoch          <= ok ? job.hdr[47:40] : 8'd0;
      payload_length <= ok ? len : 16'd0;
    end
  end

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> version == 8'd0 && payload_length == 16'd0)
    else $error("header fields leaked on failed verdict");

endmodule

// ===== sim/tb_frame_header_parser_core.sv =====
`timescale 1ns / 100ps

module tb_frame_header_parser_core
  import fhp_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    status_t     status;
    logic [7:0]  version;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [7:0]  flag_bits;
    logic [7:0]  epoch;
    logic [15:0] payload_length;
  } verdict_t;

  class verdict_scoreboard;
    logic [7:0]         local_version;
    logic [7:0]         type_low;
    logic [7:0]         type_high;
    logic [COUNT_W-1:0] byte_count;
    logic [63:0]        hdr;
    verdict_t           verdicts_due[$];
    int                 errors;

    function new();
      local_version = 8'd1;
      type_low      = 8'd1;
      type_high     = 8'd7;
      byte_count    = '0;
      hdr           = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_LOCAL_VERSION: local_version = val;
        REG_TYPE_LOW:      type_low = val;
        REG_TYPE_HIGH:     type_high = val;
        default: ;
      endcase
    endfunction

    // one accepted word; a closing byte queues its verdict
    function void take_byte(logic [7:0] b, logic last);
      verdict_t           v;
      logic [COUNT_W-1:0] total;
      logic [7:0]         ver;
      logic [7:0]         typ;
      logic [15:0]        len;
      if (byte_count < HDR_LEN) hdr[8*byte_count[2:0] +: 8] = b;
      if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
      if (!last) return;
      total      = byte_count;
      byte_count = '0;
      ver = hdr[7:0];
      typ = hdr[15:8];
      len = hdr[63:48];
      v = '{status: ST_OK, default: '0};
      if (total < HDR_LEN) v.status = ST_TRUNCATED;
      else if (ver == 8'd0 || ver != local_version) v.status = ST_BAD_VER;
      else if (typ < type_low || typ > type_high) v.status = ST_BAD_TYPE;
      else if (len > MAX_PAYLOAD) v.status = ST_BAD_LENGTH;
      else if (total < HDR_LEN + len) v.status = ST_TRUNCATED;
      if (v.status == ST_OK) begin
        v.version        = ver;
        v.frame_type     = typ;
        v.sequence_res   = hdr[31:16];
        v.flag_bits      = hdr[39:32];
        v.epoch          = hdr[47:40];
        v.payload_length = len;
      end
      verdicts_due.push_back(v);
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict word with none pending, status %0d", got.status);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      cmp("status", want.status, got.status);
      cmp("version", want.version, got.version);
      cmp("frame_type", want.frame_type, got.frame_type);
      cmp("sequence_res", want.sequence_res, got.sequence_res);
      cmp("flag_bits", want.flag_bits, got.flag_bits);
      cmp("epoch", want.epoch, got.epoch);
      cmp("payload_length", want.payload_length, got.payload_length);
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        data_valid;
  logic        data_stall;
  logic [7:0]  data_byte;
  logic        buffer_end;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  status;
  logic [7:0]  version;
  logic [7:0]  frame_type;
  logic [15:0] sequence_res;
  logic [7:0]  flag_bits;
  logic [7:0]  epoch;
  logic [15:0] payload_length;

  verdict_scoreboard sb = new();
  verdict_t seen;
  int cycles = 0;
  int idle_pct = 37;
  int stall_pct = 37;
  int hold_left = 0;
  logic [7:0] cur_ver = 8'd1;
  logic [7:0] cur_lo = 8'd1;
  logic [7:0] cur_hi = 8'd7;

  frame_header_parser_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .buffer_end(buffer_end),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .version(version),
    .frame_type(frame_type),
    .sequence_res(sequence_res),
    .flag_bits(flag_bits),
    .epoch(epoch),
    .payload_length(payload_length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall, or a counted hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_write) sb.write_reg(cfg_index, cfg_data);
    if (!rst && data_valid && !data_stall) sb.take_byte(data_byte, buffer_end);
    if (!rst && result_valid && !result_stall) begin
      seen.status         = status_t'(status);
      seen.version        = version;
      seen.frame_type     = frame_type;
      seen.sequence_res   = sequence_res;
      seen.flag_bits      = flag_bits;
      seen.epoch          = epoch;
      seen.payload_length = payload_length;
      sb.match_verdict(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    buffer_end <= last;
    do @(posedge clk); while (data_stall);
  endtask

  task automatic send_raw(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ,
                            input logic [15:0] seq, input logic [7:0] flg,
                            input logic [7:0] ep, input logic [15:0] len, input int body);
    logic [63:0] hb;
    int total;
    hb = {len, ep, flg, seq, typ, ver};
    total = 8 + body;
    for (int i = 0; i < total; i++)
      send_byte(i < 8 ? hb[8*i +: 8] : 8'($urandom_range(0, 255)), i == total - 1);
  endtask

  task automatic random_buffer(output int n);
    int r;
    int body;
    logic [7:0] ver;
    logic [7:0] typ;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 7);
      send_raw(n);
    end else if (r < 15) begin
      n = $urandom_range(8, 16);
      send_raw(n);
    end else begin
      ver = ($urandom_range(0, 99) < 85) ? cur_ver : 8'($urandom_range(0, 255));
      if (cur_lo <= cur_hi && $urandom_range(0, 99) < 85) typ = 8'($urandom_range(cur_hi, cur_lo));
      else typ = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 80) len = 16'($urandom_range(0, 12));
      else if (r < 85) len = MAX_PAYLOAD;
      else if (r < 90) len = MAX_PAYLOAD + 16'd1;
      else if (r < 95) len = 16'hFFFF;
      else len = 16'($urandom_range(1025, 65535));
      if (len >= MAX_PAYLOAD) body = $urandom_range(0, 3);
      else if (len != 0 && $urandom_range(0, 99) < 20) body = $urandom_range(0, len - 1);
      else body = len + $urandom_range(0, 3);
      send_frame(ver, typ, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), len, body);
      n = 8 + body;
    end
  endtask

  task automatic run_phase(input int quota);
    int sent;
    int n;
    sent = 0;
    while (sent < quota) begin
      random_buffer(n);
      sent += n;
    end
  endtask

  // wait for every verdict, then for the pipeline to drain
  task automatic settle();
    data_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] v, input logic [7:0] lo, input logic [7:0] hi);
    settle();
    put_reg(REG_LOCAL_VERSION, v);
    put_reg(REG_TYPE_LOW, lo);
    put_reg(REG_TYPE_HIGH, hi);
    put_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_ver = v;
    cur_lo  = lo;
    cur_hi  = hi;
  endtask

  initial begin
    logic [7:0] lo;
    logic [7:0] hi;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    data_valid   = 1'b0;
    data_byte    = '0;
    buffer_end   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings
    send_byte(8'hFF, 1'b1);
    send_frame(8'd1, 8'd7, 16'hFFFF, 8'hFF, 8'hFF, 16'd0, 0);
    send_frame(8'd0, 8'd0, 16'h0000, 8'h00, 8'h00, 16'd0, 0);
    send_frame(8'd1, 8'd0, 16'h1234, 8'h5A, 8'hA5, 16'hFFFF, 0);

    // zero version matches nothing; full type range
    set_config(8'd0, 8'd0, 8'd255);
    run_phase(270);

    // single top type, verdicts held off while bytes keep coming
    set_config(8'd255, 8'd255, 8'd255);
    hold_left = 400;
    run_phase(270);

    // empty type range
    set_config(8'($urandom_range(1, 254)), 8'd200, 8'd10);
    run_phase(270);

    lo = 8'($urandom_range(0, 255));
    hi = 8'($urandom_range(255, lo));
    set_config(8'($urandom_range(1, 255)), lo, hi);
    run_phase(270);

    // no idling on either side, then random idling and stalls again
    set_config(8'd1, 8'd0, 8'd0);
    idle_pct  = 0;
    stall_pct = 0;
    run_phase(135);
    idle_pct  = 37;
    stall_pct = 37;
    run_phase(135);

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
